// File: hdl/bidh_pkg.sv
// bidh_pkg: shared constants, types and hash helpers for the board id hash
// used by bidh_hash_core, bidh_out_fifo and board_id_string_hash
// no dependencies
`default_nettype none

package bidh_pkg;

	localparam int unsigned CharW    = 8;
	localparam int unsigned IdW      = 32;
	localparam int unsigned ProdW    = 32;
	localparam int unsigned VarW     = 16;
	localparam int unsigned FifoCntW = 2;

	localparam logic [ProdW-1:0] PROD_INIT  = 32'h811C_9DC5;
	localparam logic [VarW-1:0]  VAR_INIT   = 16'h9DC5;
	localparam logic [3:0]       TOP_NIBBLE = 4'hF;
	localparam logic [FifoCntW-1:0] FIFO_DEPTH = 2'd2;

	typedef struct packed {
		logic           emit;
		logic [IdW-1:0] id;
	} bidh_core_stat_t;

	// h * 0x01000193 mod 2^32 as shifted adds
	function automatic logic [ProdW-1:0] prod_mult(input logic [ProdW-1:0] h);
		prod_mult = h + (h << 1) + (h << 4) + (h << 7) + (h << 8) + (h << 24);
	endfunction

	// v * 0x193 mod 2^16
	function automatic logic [VarW-1:0] var_mult(input logic [VarW-1:0] v);
		var_mult = v + (v << 1) + (v << 4) + (v << 7) + (v << 8);
	endfunction

	function automatic logic [IdW-1:0] make_id(input logic [ProdW-1:0] p,
		input logic [VarW-1:0] v);
		logic [19:0] pf;
		logic [7:0]  vf;
		pf = p[19:0] ^ {8'd0, p[31:20]};
		vf = v[7:0] ^ v[15:8];
		make_id = {TOP_NIBBLE, pf, vf};
	endfunction

endpackage

`default_nettype wire

// File: hdl/board_id_string_hash.sv
// board_id_string_hash: top level, input register, hash core, result buffer
// depends on bidh_pkg, bidh_hash_core, bidh_out_fifo
//
// channel  dir  tdata bits            meaning
// s        in   [7:0]  char_byte      string byte, zero ends product then variant
// m        out  [31:0] board_id       0xF, folded product hash, folded variant hash
//
// one byte per cycle barring stalls: a beat lands in the input register, the next
// cycle it updates the hash registers through one shifted-add multiply
// a variant terminator writes its id into a two-entry buffer
// reset loads the initial hash values and the product phase
// a full buffer stalls only a terminator byte; ready does not depend on m_tready
`default_nettype none

module board_id_string_hash
	import bidh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] char_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // [31:0] board_id
);

	logic                valid_s1;
	logic [CharW-1:0]    byte_s1;
	logic                fire_s1;
	logic [FifoCntW-1:0] fifo_cnt;
	bidh_core_stat_t     core_stat;

	// terminator may retire only when the buffer has room
	assign fire_s1  = valid_s1 && (!core_stat.emit || (fifo_cnt != FIFO_DEPTH));
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	bidh_hash_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.char_byte (byte_s1),
		.stat      (core_stat)
	);

	bidh_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire_s1 && core_stat.emit),
		.push_data (core_stat.id),
		.count     (fifo_cnt),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

// File: hdl/bidh_hash_core.sv
// bidh_hash_core: product/variant hash registers, phase flag and id fold
// depends on bidh_pkg
`default_nettype none

module bidh_hash_core
	import bidh_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic [CharW-1:0] char_byte,
	output bidh_core_stat_t      stat
);

	logic [ProdW-1:0] prod_q;
	logic [VarW-1:0]  var_q;
	logic             variant_q;
	logic             is_zero;

	assign is_zero   = (char_byte == '0);
	assign stat.emit = variant_q && is_zero;
	assign stat.id   = make_id(prod_q, var_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q    <= PROD_INIT;
			var_q     <= VAR_INIT;
			variant_q <= 1'b0;
		end else if (fire) begin
			if (!variant_q) begin
				if (is_zero) begin
					variant_q <= 1'b1;
				end else begin
					prod_q <= prod_mult(prod_q) ^ {{(ProdW-CharW){1'b0}}, char_byte};
				end
			end else if (!is_zero) begin
				var_q <= var_mult(var_q) ^ {{(VarW-CharW){1'b0}}, char_byte};
			end else begin
				// variant terminator: id goes out, start over
				prod_q    <= PROD_INIT;
				var_q     <= VAR_INIT;
				variant_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/bidh_out_fifo.sv
// bidh_out_fifo: two-entry result buffer between the hash core and the output
// depends on bidh_pkg
`default_nettype none

module bidh_out_fifo
	import bidh_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire logic [IdW-1:0]  push_data,
	output logic [FifoCntW-1:0]  count,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [IdW-1:0]       m_tdata
);

	logic [IdW-1:0]      mem_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [FifoCntW-1:0] cnt_q;
	logic                pop;

	assign count    = cnt_q;
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = mem_q[rd_ptr_q];
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
